// ===== design/typec_port_attach_detach_fsm_macros.svh =====
// Assertion macros shared by the Type-C attach/detach checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TYPEC_PORT_ATTACH_DETACH_FSM_MACROS_SVH
`define TYPEC_PORT_ATTACH_DETACH_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCAD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tcad assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TCAD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("tcad assertion failed");

`endif

// ===== design/tcad_pkg.sv =====
// Types and codes for the Type-C port attach/detach state machine.
// No dependencies; used by the top level and its checker.
package tcad_pkg;

	// Power role of the port
	typedef enum logic [1:0] {
		ROLE_SNK = 2'd0,
		ROLE_SRC = 2'd1,
		ROLE_DRP = 2'd2
	} role_t;

	// Role command sent to the port controller
	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_SNK  = 2'd1,
		CMD_SRC  = 2'd2,
		CMD_DRP  = 2'd3
	} cmd_t;

	// VBUS switch action
	typedef enum logic [1:0] {
		VB_KEEP = 2'd0,
		VB_OFF  = 2'd1,
		VB_ON   = 2'd2
	} vbus_t;

	// Announced connection event
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_ATT  = 2'd1,
		EV_DET  = 2'd2
	} ev_t;

	// Toggle outcome codes
	localparam logic [1:0] TOG_SRC_FOUND = 2'd1;
	localparam logic [1:0] TOG_SNK_FOUND = 2'd2;

	// Register map
	localparam logic REG_POLICY = 1'b0;

	// Widths of the result word and the item word
	localparam int RES_W = 26;
	localparam int ITEM_W = 23;

	// One interrupt batch, packed lowest field in the lowest bits
	typedef struct packed {
		logic        commit_ok;
		logic        role_cmd_ok;
		logic        status_vbus_ok;
		logic        status_attached;
		logic [11:0] status_rp_ma;
		logic        status_cc2;
		logic [1:0]  toggle_result;
		logic        status_ok;
		logic        event_vbus;
		logic        event_cc;
		logic        event_tog;
	} item_t;

	// One result, packed lowest field in the lowest bits
	typedef struct packed {
		logic        port_pending;
		role_t       port_role;
		logic [11:0] port_rp_ma;
		logic        port_cc2;
		logic        port_attached;
		vbus_t       vbus_drive;
		logic        commit_as_source;
		logic        commit_cc2;
		logic        commit_cmd;
		cmd_t        role_cmd;
		ev_t         event_kind;
	} res_t;

endpackage

// ===== design/typec_port_attach_detach_fsm.sv =====
// Type-C port attach/detach state machine, top level.
// Depends on tcad_pkg.
//
// Usage:
//  - s_* carries one interrupt batch per request (events, CC status snapshot,
//    success of the status read, role command and attach commit).
//  - m_* returns exactly one result per request: event, role command, commit,
//    VBUS action and the port status after the batch.
//  - APB port holds the policy role at address 0. Writing 0..2 sets the policy
//    and re-initializes the port state; a write of 3 is ignored. Write only
//    while the stream is idle.
// Pipeline:
//  - A request is registered in the input register on acceptance and its result
//    in the result register, whose valid flag drives m_tvalid.
//  - One request per cycle is sustained while m_tready is high; the state
//    update is a single pass of logic between the input and result registers.
// Reset: arst_n clears the valid flags of both stages, policy and role to sink, link state to 0.
// Stall: while m_tready is low the result holds; one more request can wait
//  in the input register, then s_tready drops until the result is taken.
module typec_port_attach_detach_fsm
	import tcad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] event_tog, [1] event_cc, [2] event_vbus, [3] status_ok,
	// [5:4] toggle_result, [6] status_cc2, [18:7] status_rp_ma,
	// [19] status_attached, [20] status_vbus_ok, [21] role_cmd_ok,
	// [22] commit_ok, [23] zero
	input  logic [23:0] s_tdata,
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] event_kind, [3:2] role_cmd, [4] commit_cmd, [5] commit_cc2,
	// [6] commit_as_source, [8:7] vbus_drive, [9] port_attached, [10] port_cc2,
	// [22:11] port_rp_ma, [24:23] port_role, [25] port_pending, [31:26] zero
	output logic [31:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// pipeline and state registers
	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	res_t        res_s2;
	role_t       policy_q;
	role_t       role_q;
	logic        att_q;
	logic        pend_q;
	logic        cc2_q;
	logic [11:0] rp_q;

	// next state
	role_t       role_d;
	logic        att_d;
	logic        pend_d;
	logic        cc2_d;
	logic [11:0] rp_d;
	res_t        res_d;

	logic out_free;
	logic step_en;
	logic cfg_wr;
	logic cfg_ok;

	// decoded conditions
	logic any_ev;
	logic drp_go;
	logic drp_to_src;
	logic drp_role_ok;
	logic drp_commit_ok;
	logic src_trig;
	logic src_att_try;
	logic src_att_ok;
	logic src_det;
	logic snk_any;
	logic pend_trig;
	logic pend_cancel;
	logic pend_att;
	logic snk_trig;
	logic snk_att_try;
	logic snk_att_ok;
	logic snk_live;
	logic snk_det;
	logic det;

	// handshake
	assign out_free = !valid_s2 || m_tready;
	assign step_en  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, res_s2};

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POLICY);
	assign cfg_ok = pwdata[1:0] <= ROLE_DRP;
	assign prdata = (paddr[2] == REG_POLICY) ? {30'b0, policy_q} : 32'b0;

	// dual-role: toggle found a partner
	assign any_ev        = item_s1.event_tog || item_s1.event_cc || item_s1.event_vbus;
	assign drp_to_src    = item_s1.toggle_result == TOG_SRC_FOUND;
	assign drp_go        = (role_q == ROLE_DRP) && item_s1.event_tog && item_s1.status_ok
		&& (drp_to_src || item_s1.toggle_result == TOG_SNK_FOUND);
	assign drp_role_ok   = drp_go && item_s1.role_cmd_ok;
	assign drp_commit_ok = drp_role_ok && item_s1.commit_ok;

	// fixed source: attach on toggle, detach on CC change
	assign src_trig    = (role_q == ROLE_SRC) && item_s1.status_ok
		&& (att_q ? item_s1.event_cc : item_s1.event_tog);
	assign src_att_try = src_trig && !att_q && drp_to_src;
	assign src_att_ok  = src_att_try && item_s1.commit_ok;
	assign src_det     = src_trig && att_q && !item_s1.status_attached;

	// fixed sink: pending attach waits for VBUS
	assign snk_any     = (role_q == ROLE_SNK) && any_ev && item_s1.status_ok;
	assign pend_trig   = snk_any && pend_q && (item_s1.event_vbus || item_s1.event_cc);
	assign pend_cancel = pend_trig && item_s1.event_cc && (item_s1.status_rp_ma == 12'd0);
	assign pend_att    = pend_trig && !pend_cancel && item_s1.status_vbus_ok;
	assign snk_trig    = snk_any && !pend_q
		&& (att_q ? (item_s1.event_vbus || item_s1.event_cc) : item_s1.event_tog);
	assign snk_att_try = snk_trig && !att_q && (item_s1.toggle_result == TOG_SNK_FOUND);
	assign snk_att_ok  = snk_att_try && item_s1.commit_ok;
	assign snk_live    = snk_trig && att_q;
	assign snk_det     = snk_live && !item_s1.status_vbus_ok;
	assign det         = src_det || snk_det;

	// next-state logic
	always_comb begin
		role_d = role_q;
		att_d  = att_q;
		pend_d = pend_q;
		cc2_d  = cc2_q;
		rp_d   = rp_q;
		if (drp_role_ok) begin
			role_d = drp_to_src ? ROLE_SRC : ROLE_SNK;
			att_d  = 1'b0;
			pend_d = 1'b0;
			cc2_d  = 1'b0;
			rp_d   = 12'd0;
			if (item_s1.commit_ok) begin
				cc2_d = item_s1.status_cc2;
				rp_d  = item_s1.status_rp_ma;
				if (drp_to_src) begin
					att_d = 1'b1;
				end else begin
					pend_d = 1'b1;
				end
			end
		end
		if (src_att_ok) begin
			att_d  = 1'b1;
			pend_d = 1'b0;
			cc2_d  = item_s1.status_cc2;
			rp_d   = item_s1.status_rp_ma;
		end
		if (pend_cancel) begin
			pend_d = 1'b0;
		end
		if (pend_att) begin
			att_d  = 1'b1;
			pend_d = 1'b0;
			rp_d   = item_s1.status_rp_ma;
		end
		if (snk_att_ok) begin
			pend_d = 1'b1;
			cc2_d  = item_s1.status_cc2;
			rp_d   = item_s1.status_rp_ma;
		end
		if (snk_live && item_s1.event_cc) begin
			rp_d = item_s1.status_rp_ma;
		end
		// detach clears the link, then falls back to toggling if policy says so and the role command succeeded
		if (det) begin
			att_d  = 1'b0;
			pend_d = 1'b0;
			cc2_d  = 1'b0;
			rp_d   = 12'd0;
			if (policy_q == ROLE_DRP && item_s1.role_cmd_ok) begin
				role_d = ROLE_DRP;
			end
		end
	end

	// result logic
	always_comb begin
		res_d                  = '0;
		res_d.event_kind       = EV_NONE;
		res_d.role_cmd         = CMD_NONE;
		res_d.vbus_drive       = VB_KEEP;
		res_d.port_role        = role_d;
		res_d.port_attached    = att_d;
		res_d.port_pending     = pend_d;
		res_d.port_cc2         = cc2_d;
		res_d.port_rp_ma       = rp_d;
		if (drp_go) begin
			res_d.role_cmd = drp_to_src ? CMD_SRC : CMD_SNK;
			if (!drp_to_src) begin
				res_d.vbus_drive = VB_OFF;
			end
		end
		if (drp_role_ok) begin
			res_d.commit_cmd       = 1'b1;
			res_d.commit_cc2       = item_s1.status_cc2;
			res_d.commit_as_source = drp_to_src;
		end
		if (drp_commit_ok && drp_to_src) begin
			res_d.vbus_drive = VB_ON;
			res_d.event_kind = EV_ATT;
		end
		if (src_att_try) begin
			res_d.commit_cmd       = 1'b1;
			res_d.commit_cc2       = item_s1.status_cc2;
			res_d.commit_as_source = 1'b1;
		end
		if (src_att_ok) begin
			res_d.vbus_drive = VB_ON;
			res_d.event_kind = EV_ATT;
		end
		if (src_det) begin
			res_d.vbus_drive = VB_OFF;
		end
		if (det) begin
			res_d.event_kind = EV_DET;
			if (policy_q == ROLE_DRP) begin
				res_d.role_cmd = CMD_DRP;
			end else begin
				res_d.role_cmd = src_det ? CMD_SRC : CMD_SNK;
			end
		end
		if (pend_cancel) begin
			res_d.role_cmd = CMD_SNK;
		end
		if (pend_att) begin
			res_d.event_kind = EV_ATT;
		end
		if (snk_att_try) begin
			res_d.commit_cmd       = 1'b1;
			res_d.commit_cc2       = item_s1.status_cc2;
			res_d.commit_as_source = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_d;
		end
	end

	// port state; a policy write re-initializes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= ROLE_SNK;
			role_q   <= ROLE_SNK;
			att_q    <= 1'b0;
			pend_q   <= 1'b0;
			cc2_q    <= 1'b0;
			rp_q     <= 12'd0;
		end else if (cfg_wr && cfg_ok) begin
			policy_q <= role_t'(pwdata[1:0]);
			role_q   <= role_t'(pwdata[1:0]);
			att_q    <= 1'b0;
			pend_q   <= 1'b0;
			cc2_q    <= 1'b0;
			rp_q     <= 12'd0;
		end else if (step_en) begin
			role_q <= role_d;
			att_q  <= att_d;
			pend_q <= pend_d;
			cc2_q  <= cc2_d;
			rp_q   <= rp_d;
		end
	end

endmodule

// ===== design/tcad_checker.sv =====
// Port-level checker for the Type-C attach/detach state machine, with bind.
// Depends on tcad_pkg and typec_port_attach_detach_fsm_macros.svh.
`include "typec_port_attach_detach_fsm_macros.svh"

module tcad_assert_checker
	import tcad_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	res_t res;
	assign res = res_t'(m_tdata[RES_W-1:0]);

	// a stalled result holds
	`TCAD_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// commit arguments are zero when no commit is issued
	`TCAD_ASSERT_IMP(a_commit_args, clk, arst_n, m_tvalid && !res.commit_cmd,
		!res.commit_cc2 && !res.commit_as_source)

	// an attach announcement leaves the port attached and not pending
	`TCAD_ASSERT_IMP(a_att, clk, arst_n, m_tvalid && res.event_kind == EV_ATT,
		res.port_attached && !res.port_pending)

	// a detach announcement clears the link state
	`TCAD_ASSERT_IMP(a_det, clk, arst_n, m_tvalid && res.event_kind == EV_DET,
		!res.port_attached && !res.port_pending && res.port_rp_ma == 12'd0)

	// attached and pending never both set
	`TCAD_ASSERT_IMP(a_excl, clk, arst_n, m_tvalid, !(res.port_attached && res.port_pending))

endmodule

bind typec_port_attach_detach_fsm tcad_assert_checker u_tcad_checker (.*);
